FILE: sv/ple_pkg.sv
// ple_pkg: request/response payload types, request kinds, status codes and
// internal operation codes for the positional list engine.
// No dependencies.
`timescale 1ns / 1ps

package ple_pkg;

	localparam logic [2:0] REQ_READ   = 3'd0;
	localparam logic [2:0] REQ_FRONT  = 3'd1;
	localparam logic [2:0] REQ_BACK   = 3'd2;
	localparam logic [2:0] REQ_INSERT = 3'd3;
	localparam logic [2:0] REQ_DELETE = 3'd4;

	localparam logic [1:0] ST_DONE   = 2'd0;
	localparam logic [1:0] ST_BADPOS = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;

	localparam int POS_W = 7;
	localparam int VAL_W = 32;

	typedef struct packed {
		logic [2:0]              req_type;
		logic [POS_W-1:0]        position;
		logic signed [VAL_W-1:0] item_value;
	} req_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] read_value;
		logic [1:0]              status;
		logic [POS_W-1:0]        entry_count;
	} rsp_t;

	// decoded operation for one transaction
	typedef enum logic [2:0] {
		OP_REJECT    = 3'd0,
		OP_READ      = 3'd1,
		OP_INS_PUT   = 3'd2,
		OP_INS_SHIFT = 3'd3,
		OP_DEL_DROP  = 3'd4,
		OP_DEL_SHIFT = 3'd5
	} op_t;

	typedef struct packed {
		logic accept;
		logic eval;
		logic step;
		logic write_item;
		logic finish;
	} ple_cmd_t;

	typedef struct packed {
		op_t  eval_op;
		op_t  op;
		logic last;
		logic out_free;
	} ple_stat_t;

endpackage

FILE: sv/positional_list_engine_core.sv
// positional_list_engine_core: ordered list of up to CAPACITY signed 32-bit
// values addressed by position, one request in flight at a time. A read or a
// rejected request moves no entries; an insert or a delete moves the entries
// behind its position one by one. The pace is set by the entry store, which
// has one read and one write port: each moved entry costs one read and one
// write, streamed one per cycle. The result sits in an output register, so a
// new request is taken as soon as the engine is back in idle, even while the
// previous result waits. Depends on ple_pkg, ple_ctrl and ple_dp.
`timescale 1ns / 1ps

module positional_list_engine_core
	import ple_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	ple_cmd_t  cmd;
	ple_stat_t st;

	ple_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.st        (st),
		.cmd       (cmd)
	);

	ple_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.st        (st),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

`ifndef ASSERT_OFF
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another transaction is in flight");

	a_finish_loads: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> rsp_valid)
		else $error("finished transaction did not reach the result register");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_FULL) |-> rsp.entry_count == POS_W'(CAPACITY))
		else $error("list-full status with a count below capacity");

	a_fail_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != ST_DONE) |-> rsp.read_value == '1)
		else $error("failed transaction returned a value other than all ones");
`endif

endmodule

FILE: sv/ple_dp.sv
// ple_dp: datapath of the positional list engine: request register, entry
// store, shift pointer, one-stage write-back pipe, count and result register.
// Depends on ple_pkg.
`timescale 1ns / 1ps

module ple_dp
	import ple_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  req_t      req,
	input  ple_cmd_t  cmd,
	output ple_stat_t st,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_t      rsp
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int WW = (CW > POS_W) ? CW : POS_W;
	localparam logic [WW-1:0] CAP_W = WW'(CAPACITY);

	logic [VAL_W-1:0] mem [CAPACITY];

	req_t             req_q;
	logic [CW-1:0]    cnt_q;
	op_t              op_q;
	logic [1:0]       status_q;
	logic [AW-1:0]    tgt_q;
	logic [AW-1:0]    ptr_q;
	logic [AW-1:0]    end_q;
	logic [VAL_W-1:0] rdata_q;
	logic             wr_pend_s1;
	logic [AW-1:0]    wr_addr_s1;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic [WW-1:0]    cnt_w;
	logic [WW-1:0]    pos_w;
	logic [WW-1:0]    tgt_w;
	logic [WW-1:0]    cm1_w;
	logic [WW-1:0]    pp1_w;
	logic [WW-1:0]    ptr0_w;
	logic [WW-1:0]    end0_w;
	logic [WW-1:0]    new_cnt_w;
	logic             ins;
	op_t              eval_op;
	logic [1:0]       eval_st;
	logic [CW-1:0]    new_cnt;
	logic             mem_we;
	logic [AW-1:0]    mem_wa;
	logic [VAL_W-1:0] mem_wd;
	logic             mem_re;
	logic [AW-1:0]    mem_ra;
	logic             op_ins;

	assign cnt_w = WW'(cnt_q);
	assign pos_w = WW'(req_q.position);
	assign cm1_w = cnt_w - WW'(1);
	assign pp1_w = pos_w + WW'(1);

	// classify the held request against the current count
	always_comb begin
		ins     = 1'b0;
		tgt_w   = pos_w;
		eval_op = OP_REJECT;
		eval_st = ST_BADPOS;
		unique case (req_q.req_type)
			REQ_READ: begin
				if (pos_w < cnt_w) begin
					eval_op = OP_READ;
					eval_st = ST_DONE;
				end
			end
			REQ_FRONT: begin
				ins   = 1'b1;
				tgt_w = '0;
			end
			REQ_BACK: begin
				ins   = 1'b1;
				tgt_w = cnt_w;
			end
			REQ_INSERT: begin
				ins = 1'b1;
			end
			REQ_DELETE: begin
				if (pos_w < cnt_w) begin
					eval_op = (pos_w == cm1_w) ? OP_DEL_DROP : OP_DEL_SHIFT;
					eval_st = ST_DONE;
				end
			end
			default: begin
			end
		endcase
		if (ins) begin
			priority if (tgt_w > cnt_w) begin
				eval_st = ST_BADPOS;
			end else if (cnt_w >= CAP_W) begin
				eval_st = ST_FULL;
			end else begin
				eval_st = ST_DONE;
				eval_op = (tgt_w == cnt_w) ? OP_INS_PUT : OP_INS_SHIFT;
			end
		end
	end

	assign op_ins = (op_q == OP_INS_SHIFT) || (op_q == OP_INS_PUT);

	// insert walks down from the last entry, delete walks up past the hole
	assign ptr0_w = ins ? cm1_w : pp1_w;
	assign end0_w = ins ? tgt_w : cm1_w;

	always_comb begin
		unique case (op_q)
			OP_INS_PUT, OP_INS_SHIFT: new_cnt = cnt_q + CW'(1);
			OP_DEL_DROP, OP_DEL_SHIFT: new_cnt = cnt_q - CW'(1);
			default: new_cnt = cnt_q;
		endcase
	end
	assign new_cnt_w = WW'(new_cnt);

	assign mem_re = (cmd.eval && (eval_op == OP_READ)) || cmd.step;
	assign mem_ra = cmd.eval ? pos_w[AW-1:0] : ptr_q;
	assign mem_we = wr_pend_s1 || cmd.write_item;
	assign mem_wa = wr_pend_s1 ? wr_addr_s1 : tgt_q;
	assign mem_wd = wr_pend_s1 ? rdata_q : req_q.item_value;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q <= req;
		end
		if (cmd.eval) begin
			status_q <= eval_st;
			tgt_q    <= tgt_w[AW-1:0];
			ptr_q    <= ptr0_w[AW-1:0];
			end_q    <= end0_w[AW-1:0];
		end else if (cmd.step) begin
			ptr_q <= op_ins ? ptr_q - AW'(1) : ptr_q + AW'(1);
		end
		if (cmd.step) begin
			wr_addr_s1 <= op_ins ? ptr_q + AW'(1) : ptr_q - AW'(1);
		end
		if (cmd.finish) begin
			rsp_q.read_value  <= (op_q == OP_READ) ? rdata_q : '1;
			rsp_q.status      <= status_q;
			rsp_q.entry_count <= new_cnt_w[POS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			op_q        <= OP_REJECT;
			wr_pend_s1  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.eval) begin
				op_q <= eval_op;
			end
			wr_pend_s1 <= cmd.step;
			if (cmd.finish) begin
				cnt_q       <= new_cnt;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign st.eval_op  = eval_op;
	assign st.op       = op_q;
	assign st.last     = (ptr_q == end_q);
	assign st.out_free = !rsp_valid_q || rsp_ready;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: sv/ple_ctrl.sv
// ple_ctrl: controller state machine of the positional list engine; sequences
// accept, classify, shift, drain, item write and result hand-off.
// Depends on ple_pkg.
`timescale 1ns / 1ps

module ple_ctrl
	import ple_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  ple_stat_t st,
	output ple_cmd_t  cmd
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_EVAL   = 6'b000010,
		S_SHIFT  = 6'b000100,
		S_DRAIN  = 6'b001000,
		S_WRITE  = 6'b010000,
		S_FINISH = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.accept = req_valid;
				if (req_valid) begin
					state_d = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				unique case (st.eval_op)
					OP_INS_SHIFT, OP_DEL_SHIFT: state_d = S_SHIFT;
					OP_INS_PUT: state_d = S_WRITE;
					default: state_d = S_FINISH;
				endcase
			end
			S_SHIFT: begin
				cmd.step = 1'b1;
				if (st.last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				// let the last moved entry land before the write port is reused
				state_d = (st.op == OP_INS_SHIFT) ? S_WRITE : S_FINISH;
			end
			S_WRITE: begin
				cmd.write_item = 1'b1;
				state_d        = S_FINISH;
			end
			S_FINISH: begin
				// hold until the result register is free
				cmd.finish = st.out_free;
				if (st.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_ready = (state_q == S_IDLE);

endmodule
